[rtl/gdc_pkg.sv]
// Package of the gaze direction controller: types, codes and constants.
// Used by the front, queue, easing unit, back and top level; depends on nothing.
package gdc_pkg;

  // Half and full turn in 1/128 degree units, signed delta width
  localparam logic signed [17:0] HALF_TURN = 18'sd23040;
  localparam logic signed [17:0] FULL_TURN = 18'sd46080;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE        = 3'd0,
    CFG_STEP_SIZE       = 3'd1,
    CFG_YAW_LIMIT       = 3'd2,
    CFG_PITCH_LIMIT     = 3'd3,
    CFG_RETURN_MS       = 3'd4,
    CFG_IDLE_TIMEOUT    = 3'd5,
    CFG_PATROL_INTERVAL = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [14:0] deadzone;
    logic [4:0]  step_size;
    logic [5:0]  yaw_limit;
    logic [5:0]  pitch_limit;
    logic [15:0] return_ms;
    logic [31:0] idle_wait_ms;
    logic [15:0] patrol_interval_ms;
  } cfg_t;

  // Motion seen on one axis
  typedef enum logic [1:0] {
    MOV_NONE = 2'd0,
    MOV_POS  = 2'd1,
    MOV_NEG  = 2'd2
  } mov_t;

  // Classified item handed from front to back
  typedef struct packed {
    mov_t        ydir;
    mov_t        pdir;
    logic [31:0] now_ms;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_EASE,
    B_RESULT
  } back_state_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_MUL1,
    E_MUL2,
    E_MUL3,
    E_SETUP,
    E_DIV,
    E_FIN
  } ease_state_t;

  // Easing unit request and response
  typedef struct packed {
    logic              start;
    logic signed [6:0] origin_yaw;
    logic signed [6:0] origin_pitch;
    logic [15:0]       rem;
  } ease_req_t;

  typedef struct packed {
    logic              done;
    logic signed [6:0] yaw;
    logic signed [6:0] pitch;
  } ease_rsp_t;

endpackage

[rtl/gdc_in_if.sv]
// Input item channel of the gaze direction controller.
// Depends on nothing.
interface gdc_in_if;
  logic               valid;
  logic               ready;
  logic               sensor_reset;
  logic               has_sample;
  logic signed [15:0] yaw_angle;
  logic signed [15:0] pitch_angle;
  logic [31:0]        now_ms;

  modport source (output valid, sensor_reset, has_sample, yaw_angle, pitch_angle, now_ms,
                  input ready);
  modport sink (input valid, sensor_reset, has_sample, yaw_angle, pitch_angle, now_ms,
                output ready);
endinterface

[rtl/gdc_out_if.sv]
// Result item channel of the gaze direction controller.
// Depends on nothing.
interface gdc_out_if;
  logic              valid;
  logic              ready;
  logic signed [6:0] yaw_pos;
  logic signed [6:0] pitch_pos;
  logic              redraw;

  modport source (output valid, yaw_pos, pitch_pos, redraw, input ready);
  modport sink (input valid, yaw_pos, pitch_pos, redraw, output ready);
endinterface

[rtl/gdc_front.sv]
// Front part: accepts input items, tracks the previous sample and
// classifies yaw/pitch motion. Depends on gdc_pkg and gdc_in_if.
module gdc_front (
  input  logic             clk,
  input  logic             rst_n,
  gdc_in_if.sink           in_item,
  input  logic [14:0]      deadzone,
  input  logic             q_full,
  output logic             q_push,
  output gdc_pkg::cmd_t    q_data
);

  logic signed [15:0] prev_yaw_r, prev_yaw_nxt;
  logic signed [15:0] prev_pitch_r, prev_pitch_nxt;
  logic               prev_valid_r, prev_valid_nxt;
  logic               accept;
  logic               prev_ok;

  // Wrapped delta against deadzone gives the motion direction
  function automatic gdc_pkg::mov_t classify(input logic signed [15:0] a,
                                             input logic signed [15:0] p,
                                             input logic [14:0] dz);
    logic signed [17:0] d;
    logic signed [17:0] w;
    logic [17:0]        mag;
    gdc_pkg::mov_t      res;
    d = 18'(a) - 18'(p);
    w = d;
    if (d > gdc_pkg::HALF_TURN) begin
      w = d - gdc_pkg::FULL_TURN;
    end else if (d < -gdc_pkg::HALF_TURN) begin
      w = d + gdc_pkg::FULL_TURN;
    end
    mag = w[17] ? 18'(-w) : 18'(w);
    res = gdc_pkg::MOV_NONE;
    if (mag > {3'b000, dz}) begin
      res = w[17] ? gdc_pkg::MOV_NEG : gdc_pkg::MOV_POS;
    end
    return res;
  endfunction

  assign in_item.ready = !q_full;
  assign accept        = in_item.valid && !q_full;
  assign q_push        = accept;
  assign prev_ok       = prev_valid_r && !in_item.sensor_reset;

  // Classify and update the sample history
  always_comb begin
    prev_yaw_nxt   = prev_yaw_r;
    prev_pitch_nxt = prev_pitch_r;
    prev_valid_nxt = prev_valid_r;
    q_data.ydir    = gdc_pkg::MOV_NONE;
    q_data.pdir    = gdc_pkg::MOV_NONE;
    q_data.now_ms  = in_item.now_ms;
    if (in_item.has_sample && prev_ok) begin
      q_data.ydir = classify(in_item.yaw_angle, prev_yaw_r, deadzone);
      q_data.pdir = classify(in_item.pitch_angle, prev_pitch_r, deadzone);
    end
    if (accept) begin
      if (in_item.sensor_reset) prev_valid_nxt = 1'b0;
      if (in_item.has_sample) begin
        prev_yaw_nxt   = in_item.yaw_angle;
        prev_pitch_nxt = in_item.pitch_angle;
        prev_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_yaw_r   <= '0;
      prev_pitch_r <= '0;
      prev_valid_r <= 1'b0;
    end else begin
      prev_yaw_r   <= prev_yaw_nxt;
      prev_pitch_r <= prev_pitch_nxt;
      prev_valid_r <= prev_valid_nxt;
    end
  end

endmodule

[rtl/gdc_cmd_fifo.sv]
// Two-entry queue of classified items between front and back.
// Depends on gdc_pkg.
module gdc_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gdc_pkg::cmd_t push_data,
  input  logic          pop,
  output gdc_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  gdc_pkg::cmd_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

[rtl/gdc_ease.sv]
// Easing unit: origin * (rem/R)^3 rounded to whole steps, for yaw and pitch.
// Registered multiplies then an 8-step restoring divider. Depends on gdc_pkg.
module gdc_ease (
  input  logic               clk,
  input  logic               rst_n,
  input  gdc_pkg::ease_req_t req,
  input  logic [15:0]        return_ms,
  input  logic [4:0]         step_size,
  output gdc_pkg::ease_rsp_t rsp
);

  gdc_pkg::ease_state_t st_r, st_nxt;
  logic [6:0]  abs_y_r, abs_p_r;
  logic        neg_y_r, neg_p_r;
  logic [15:0] rem_r;
  logic [31:0] r2_r, m2_r;
  logic [47:0] r3_r, m3_r;
  logic [52:0] den_r;
  logic [54:0] mag_y_r, mag_p_r;
  logic [60:0] dsh_r;
  logic [60:0] rmd_y_r, rmd_p_r;
  logic [7:0]  q_y_r, q_p_r;
  logic [2:0]  cnt_r;
  logic        done_r;
  logic signed [6:0] res_y_r, res_p_r;
  logic        ge_y, ge_p;
  logic [12:0] prod_y, prod_p;

  // Round-away magnitude to signed position with saturation
  function automatic logic signed [6:0] sat_pos(input logic [12:0] p, input logic neg);
    logic signed [6:0] v;
    if (neg) begin
      v = (p > 13'd64) ? -7'sd64 : 7'(-p);
    end else begin
      v = (p > 13'd63) ? 7'sd63 : 7'(p);
    end
    return v;
  endfunction

  assign ge_y   = (rmd_y_r >= dsh_r);
  assign ge_p   = (rmd_p_r >= dsh_r);
  assign prod_y = 13'(q_y_r * step_size);
  assign prod_p = 13'(q_p_r * step_size);

  assign rsp.done  = done_r;
  assign rsp.yaw   = res_y_r;
  assign rsp.pitch = res_p_r;

  // Sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      gdc_pkg::E_IDLE:  if (req.start) st_nxt = gdc_pkg::E_MUL1;
      gdc_pkg::E_MUL1:  st_nxt = gdc_pkg::E_MUL2;
      gdc_pkg::E_MUL2:  st_nxt = gdc_pkg::E_MUL3;
      gdc_pkg::E_MUL3:  st_nxt = gdc_pkg::E_SETUP;
      gdc_pkg::E_SETUP: st_nxt = gdc_pkg::E_DIV;
      gdc_pkg::E_DIV:   if (cnt_r == 3'd0) st_nxt = gdc_pkg::E_FIN;
      gdc_pkg::E_FIN:   st_nxt = gdc_pkg::E_IDLE;
      default:          st_nxt = gdc_pkg::E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= gdc_pkg::E_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == gdc_pkg::E_FIN);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (st_r)
      gdc_pkg::E_IDLE: begin
        abs_y_r <= req.origin_yaw[6] ? 7'(-req.origin_yaw) : 7'(req.origin_yaw);
        abs_p_r <= req.origin_pitch[6] ? 7'(-req.origin_pitch) : 7'(req.origin_pitch);
        neg_y_r <= req.origin_yaw[6];
        neg_p_r <= req.origin_pitch[6];
        rem_r   <= req.rem;
      end
      gdc_pkg::E_MUL1: begin
        r2_r <= return_ms * return_ms;
        m2_r <= rem_r * rem_r;
      end
      gdc_pkg::E_MUL2: begin
        r3_r <= r2_r * return_ms;
        m3_r <= m2_r * rem_r;
      end
      gdc_pkg::E_MUL3: begin
        den_r   <= {5'b0, r3_r} * step_size;
        mag_y_r <= {7'b0, m3_r} * abs_y_r;
        mag_p_r <= {7'b0, m3_r} * abs_p_r;
      end
      gdc_pkg::E_SETUP: begin
        rmd_y_r <= 61'({mag_y_r, 1'b0}) + 61'(den_r);
        rmd_p_r <= 61'({mag_p_r, 1'b0}) + 61'(den_r);
        dsh_r   <= {den_r, 8'b0};
        cnt_r   <= 3'd7;
        q_y_r   <= '0;
        q_p_r   <= '0;
      end
      gdc_pkg::E_DIV: begin
        if (ge_y) rmd_y_r <= rmd_y_r - dsh_r;
        if (ge_p) rmd_p_r <= rmd_p_r - dsh_r;
        q_y_r <= {q_y_r[6:0], ge_y};
        q_p_r <= {q_p_r[6:0], ge_p};
        dsh_r <= {1'b0, dsh_r[60:1]};
        cnt_r <= cnt_r - 3'd1;
      end
      gdc_pkg::E_FIN: begin
        res_y_r <= sat_pos(prod_y, neg_y_r);
        res_p_r <= sat_pos(prod_p, neg_p_r);
      end
      default: ;
    endcase
  end

endmodule

[rtl/gdc_back.sv]
// Back part: position state, motion/patrol/return/idle handling and the
// result register. Depends on gdc_pkg and gdc_out_if; drives gdc_ease.
module gdc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  gdc_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  gdc_pkg::cmd_t      q_head,
  output logic               q_pop,
  output gdc_pkg::ease_req_t ease_req,
  input  gdc_pkg::ease_rsp_t ease_rsp,
  gdc_out_if.source          out_item
);

  gdc_pkg::back_state_t state_r, state_nxt;
  gdc_pkg::cmd_t        cmd_r, cmd_nxt;
  logic signed [6:0] yaw_r, yaw_nxt, pitch_r, pitch_nxt;
  logic signed [6:0] shown_yaw_r, shown_yaw_nxt, shown_pitch_r, shown_pitch_nxt;
  logic signed [6:0] org_yaw_r, org_yaw_nxt, org_pitch_r, org_pitch_nxt;
  logic        returning_r, returning_nxt;
  logic        patrolling_r, patrolling_nxt;
  logic        patrol_neg_r, patrol_neg_nxt;
  logic [31:0] ret_start_r, ret_start_nxt;
  logic [31:0] last_motion_r, last_motion_nxt;
  logic [31:0] last_patrol_r, last_patrol_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic signed [6:0] out_yaw_r, out_yaw_nxt, out_pitch_r, out_pitch_nxt;
  logic        out_redraw_r, out_redraw_nxt;

  logic              ymov, pmov;
  logic signed [6:0] ybase, pbase;
  logic signed [8:0] ysum, psum, pat_sum, ylim_s;
  logic [4:0]        step;
  logic [31:0]       start_v, elapsed;

  // Symmetric saturation to +-lim
  function automatic logic signed [6:0] clamp_sym(input logic signed [8:0] v,
                                                  input logic [5:0] lim);
    logic signed [8:0] l;
    logic signed [6:0] r;
    l = $signed({3'b000, lim});
    if (v > l) r = 7'(l);
    else if (v < -l) r = 7'(-l);
    else r = 7'(v);
    return r;
  endfunction

  assign step    = cfg.step_size;
  assign ymov    = (cmd_r.ydir != gdc_pkg::MOV_NONE);
  assign pmov    = (cmd_r.pdir != gdc_pkg::MOV_NONE);
  assign ybase   = patrolling_r ? 7'sd0 : yaw_r;
  assign pbase   = patrolling_r ? 7'sd0 : pitch_r;
  assign ysum    = (cmd_r.ydir == gdc_pkg::MOV_NEG) ? 9'(ybase) - $signed({4'b0, step})
                                                    : 9'(ybase) + $signed({4'b0, step});
  // Falling pitch raises the position
  assign psum    = (cmd_r.pdir == gdc_pkg::MOV_POS) ? 9'(pbase) - $signed({4'b0, step})
                                                    : 9'(pbase) + $signed({4'b0, step});
  assign pat_sum = patrol_neg_r ? 9'(yaw_r) - $signed({4'b0, step})
                                : 9'(yaw_r) + $signed({4'b0, step});
  assign ylim_s  = $signed({3'b000, cfg.yaw_limit});
  assign start_v = returning_r ? ret_start_r : cmd_r.now_ms;
  assign elapsed = cmd_r.now_ms - start_v;

  assign out_item.valid     = out_valid_r;
  assign out_item.yaw_pos   = out_yaw_r;
  assign out_item.pitch_pos = out_pitch_r;
  assign out_item.redraw    = out_redraw_r;

  // Next state and outputs
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    yaw_nxt         = yaw_r;
    pitch_nxt       = pitch_r;
    shown_yaw_nxt   = shown_yaw_r;
    shown_pitch_nxt = shown_pitch_r;
    org_yaw_nxt     = org_yaw_r;
    org_pitch_nxt   = org_pitch_r;
    returning_nxt   = returning_r;
    patrolling_nxt  = patrolling_r;
    patrol_neg_nxt  = patrol_neg_r;
    ret_start_nxt   = ret_start_r;
    last_motion_nxt = last_motion_r;
    last_patrol_nxt = last_patrol_r;
    out_valid_nxt   = out_valid_r && !out_item.ready;
    out_yaw_nxt     = out_yaw_r;
    out_pitch_nxt   = out_pitch_r;
    out_redraw_nxt  = out_redraw_r;
    q_pop           = 1'b0;
    ease_req.start        = 1'b0;
    ease_req.origin_yaw   = org_yaw_nxt;
    ease_req.origin_pitch = org_pitch_nxt;
    ease_req.rem          = cfg.return_ms - elapsed[15:0];

    case (state_r)
      gdc_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          state_nxt = gdc_pkg::B_EXEC;
        end
      end
      gdc_pkg::B_EXEC: begin
        state_nxt = gdc_pkg::B_RESULT;
        if (ymov || pmov) begin
          // Motion: step and saturate, leaving patrol and return
          returning_nxt   = 1'b0;
          patrolling_nxt  = 1'b0;
          last_motion_nxt = cmd_r.now_ms;
          yaw_nxt   = ymov ? clamp_sym(ysum, cfg.yaw_limit) : ybase;
          pitch_nxt = pmov ? clamp_sym(psum, cfg.pitch_limit) : pbase;
        end else if (patrolling_r) begin
          // Patrol sweep step when the interval has passed
          if ((cmd_r.now_ms - last_patrol_r) >= {16'b0, cfg.patrol_interval_ms}) begin
            last_patrol_nxt = cmd_r.now_ms;
            pitch_nxt       = 7'sd0;
            if (pat_sum >= ylim_s) begin
              yaw_nxt        = 7'(ylim_s);
              patrol_neg_nxt = 1'b1;
            end else if (pat_sum <= -ylim_s) begin
              yaw_nxt        = 7'(-ylim_s);
              patrol_neg_nxt = 1'b0;
            end else begin
              yaw_nxt = 7'(pat_sum);
            end
          end
        end else if (yaw_r != 7'sd0 || pitch_r != 7'sd0) begin
          // Eased return to center
          if (!returning_r) begin
            org_yaw_nxt   = yaw_r;
            org_pitch_nxt = pitch_r;
          end
          returning_nxt = 1'b1;
          ret_start_nxt = start_v;
          ease_req.origin_yaw   = org_yaw_nxt;
          ease_req.origin_pitch = org_pitch_nxt;
          if (elapsed >= {16'b0, cfg.return_ms}) begin
            yaw_nxt       = 7'sd0;
            pitch_nxt     = 7'sd0;
            returning_nxt = 1'b0;
          end else begin
            ease_req.start = 1'b1;
            state_nxt      = gdc_pkg::B_EASE;
          end
        end else begin
          // Centered and still: start patrol after the idle timeout
          if ((cmd_r.now_ms - last_motion_r) >= cfg.idle_wait_ms) begin
            patrolling_nxt  = 1'b1;
            last_patrol_nxt = cmd_r.now_ms;
            patrol_neg_nxt  = 1'b0;
          end
        end
      end
      gdc_pkg::B_EASE: begin
        if (ease_rsp.done) begin
          yaw_nxt   = ease_rsp.yaw;
          pitch_nxt = ease_rsp.pitch;
          state_nxt = gdc_pkg::B_RESULT;
        end
      end
      gdc_pkg::B_RESULT: begin
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt   = 1'b1;
          out_yaw_nxt     = yaw_r;
          out_pitch_nxt   = pitch_r;
          out_redraw_nxt  = (yaw_r != shown_yaw_r) || (pitch_r != shown_pitch_r);
          shown_yaw_nxt   = yaw_r;
          shown_pitch_nxt = pitch_r;
          state_nxt       = gdc_pkg::B_IDLE;
        end
      end
      default: state_nxt = gdc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= gdc_pkg::B_IDLE;
      yaw_r         <= '0;
      pitch_r       <= '0;
      shown_yaw_r   <= '0;
      shown_pitch_r <= '0;
      org_yaw_r     <= '0;
      org_pitch_r   <= '0;
      returning_r   <= 1'b0;
      patrolling_r  <= 1'b0;
      patrol_neg_r  <= 1'b0;
      ret_start_r   <= '0;
      last_motion_r <= '0;
      last_patrol_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      yaw_r         <= yaw_nxt;
      pitch_r       <= pitch_nxt;
      shown_yaw_r   <= shown_yaw_nxt;
      shown_pitch_r <= shown_pitch_nxt;
      org_yaw_r     <= org_yaw_nxt;
      org_pitch_r   <= org_pitch_nxt;
      returning_r   <= returning_nxt;
      patrolling_r  <= patrolling_nxt;
      patrol_neg_r  <= patrol_neg_nxt;
      ret_start_r   <= ret_start_nxt;
      last_motion_r <= last_motion_nxt;
      last_patrol_r <= last_patrol_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    out_yaw_r    <= out_yaw_nxt;
    out_pitch_r  <= out_pitch_nxt;
    out_redraw_r <= out_redraw_nxt;
  end

endmodule

[rtl/gaze_direction_controller.sv]
// Top level of the gaze direction controller: configuration registers,
// front, queue, back and easing unit. Depends on gdc_pkg and both channel interfaces.
//
// Usage:
//  - in_item carries one frame: sensor_reset, has_sample, yaw/pitch angle
//    (1/128 degree) and now_ms. An item is taken when valid and ready are high.
//  - out_item gives one result per frame: yaw_pos, pitch_pos and redraw.
//  - cfg_we/cfg_index/cfg_wdata write one register per cycle; write only while
//    the block holds no unfinished item.
// Timing:
//  - The front classifies an item in the cycle it is accepted and queues it
//    (two entries); in_ready drops only when that queue is full.
//  - The back steps through pop, execute and result register per item and takes
//    the next item once the result is registered. With the eased return it adds
//    three registered multiply stages, a setup step, an 8-step restoring divider,
//    a finish step and the handback, both axes in parallel.
// Reset: synchronous, rst_n low. Positions, history and queue clear and the
//  registers take their default values.
// Stall: a result holds in the output register until taken; the back waits
//  there while the front keeps filling the queue.
module gaze_direction_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  gdc_in_if.sink                           in_item,
  gdc_out_if.source                        out_item,
  input  logic                             cfg_we,
  input  logic [gdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gdc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  gdc_pkg::cfg_t      cfg_r;
  gdc_pkg::cmd_t      q_data, q_head;
  logic               q_push, q_pop, q_full, q_empty;
  gdc_pkg::ease_req_t ease_req;
  gdc_pkg::ease_rsp_t ease_rsp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone           <= 15'd128;
      cfg_r.step_size          <= 5'd4;
      cfg_r.yaw_limit          <= 6'd20;
      cfg_r.pitch_limit        <= 6'd10;
      cfg_r.return_ms          <= 16'd500;
      cfg_r.idle_wait_ms       <= 32'd120000;
      cfg_r.patrol_interval_ms <= 16'd500;
    end else if (cfg_we) begin
      case (gdc_pkg::cfg_idx_t'(cfg_index))
        gdc_pkg::CFG_DEADZONE:        cfg_r.deadzone           <= cfg_wdata[14:0];
        gdc_pkg::CFG_STEP_SIZE:       cfg_r.step_size          <= cfg_wdata[4:0];
        gdc_pkg::CFG_YAW_LIMIT:       cfg_r.yaw_limit          <= cfg_wdata[5:0];
        gdc_pkg::CFG_PITCH_LIMIT:     cfg_r.pitch_limit        <= cfg_wdata[5:0];
        gdc_pkg::CFG_RETURN_MS:       cfg_r.return_ms          <= cfg_wdata[15:0];
        gdc_pkg::CFG_IDLE_TIMEOUT:    cfg_r.idle_wait_ms       <= cfg_wdata[31:0];
        gdc_pkg::CFG_PATROL_INTERVAL: cfg_r.patrol_interval_ms <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  gdc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .deadzone (cfg_r.deadzone),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  gdc_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  gdc_ease u_ease (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (ease_req),
    .return_ms (cfg_r.return_ms),
    .step_size (cfg_r.step_size),
    .rsp       (ease_rsp)
  );

  gdc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .ease_req (ease_req),
    .ease_rsp (ease_rsp),
    .out_item (out_item)
  );

endmodule

[rtl/gdc_checker.sv]
// Port-level checks of the gaze direction controller and their binding.
// Depends only on the top level's ports.
module gdc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [6:0] out_yaw_pos,
  input logic signed [6:0] out_pitch_pos,
  input logic              out_redraw
);

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_yaw_pos) && $stable(out_pitch_pos)
                                && $stable(out_redraw))
    else $error("result changed while stalled");

  // Reset leaves no result pending
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // Reset empties the queue, so input is accepted next
  assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind gaze_direction_controller gdc_checker u_gdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_item.ready),
  .out_valid     (out_item.valid),
  .out_ready     (out_item.ready),
  .out_yaw_pos   (out_item.yaw_pos),
  .out_pitch_pos (out_item.pitch_pos),
  .out_redraw    (out_item.redraw)
);

[tb/tb_top.sv]
// Self-checking testbench of gaze_direction_controller: directed and random frames
// with idling on both channels, checked against an in-bench position predictor.
// Depends on gdc_pkg, gdc_in_if, gdc_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    bit               sensor_reset;
    bit               has_sample;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic [31:0]      now_ms;
  } frame_t;

  typedef struct {
    logic signed [6:0] yaw_pos;
    logic signed [6:0] pitch_pos;
    bit                redraw;
  } gaze_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [gdc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gdc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  gdc_in_if  in_ch ();
  gdc_out_if out_ch ();

  gaze_direction_controller i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch.sink),
    .out_item (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the registers and state
  int unsigned m_deadzone, m_step, m_yaw_lim, m_pitch_lim, m_return_ms;
  logic [31:0] m_idle_to, m_patrol_iv;
  int m_yaw, m_pitch, m_shown_yaw, m_shown_pitch, m_prev_yaw, m_prev_pitch;
  bit m_prev_ok, m_returning, m_patrolling, m_toward_neg;
  logic [31:0] m_ret_start, m_last_motion, m_last_patrol;
  int m_org_yaw, m_org_pitch;

  frame_t pending_frames[$];
  gaze_t  expected_gaze[$];
  int     mismatches = 0;
  bit     quiet = 1'b0;

  function automatic int wrap_turn(int d);
    if (d > 23040) d -= 46080;
    if (d < -23040) d += 46080;
    return d;
  endfunction

  function automatic int motion_of(int d);
    int a;
    a = d < 0 ? -d : d;
    if (a > m_deadzone) return d > 0 ? 1 : -1;
    return 0;
  endfunction

  function automatic int clamp_to(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Cubic ease toward center, rounded half away from zero to whole steps
  function automatic int ease_pos(int origin, logic [31:0] elapsed);
    longint unsigned r, rem, den, mag, q;
    longint p;
    if (m_step == 0) return 0;
    r = m_return_ms;
    rem = m_return_ms - elapsed;
    den = r * r * r * m_step;
    mag = longint'(origin < 0 ? -origin : origin) * rem * rem * rem;
    q = (2 * mag + den) / (2 * den);
    p = longint'(q * m_step);
    if (origin < 0) p = -p;
    if (p > 63) p = 63;
    if (p < -64) p = -64;
    return int'(p);
  endfunction

  function automatic gaze_t next_gaze(frame_t f);
    int ydir, pdir, ya, pa;
    logic [31:0] el;
    gaze_t g;
    ydir = 0;
    pdir = 0;
    if (f.sensor_reset) m_prev_ok = 1'b0;
    if (f.has_sample) begin
      ya = f.yaw_angle;
      pa = f.pitch_angle;
      if (m_prev_ok) begin
        ydir = motion_of(wrap_turn(ya - m_prev_yaw));
        pdir = motion_of(wrap_turn(pa - m_prev_pitch));
      end
      m_prev_yaw = ya;
      m_prev_pitch = pa;
      m_prev_ok = 1'b1;
    end
    if (ydir != 0 || pdir != 0) begin
      m_returning = 1'b0;
      if (m_patrolling) begin
        m_yaw = 0;
        m_pitch = 0;
      end
      m_patrolling = 1'b0;
      m_last_motion = f.now_ms;
      if (ydir != 0) m_yaw = clamp_to(m_yaw + ydir * int'(m_step), m_yaw_lim);
      if (pdir != 0) m_pitch = clamp_to(m_pitch - pdir * int'(m_step), m_pitch_lim);
    end else if (m_patrolling) begin
      if (f.now_ms - m_last_patrol >= m_patrol_iv) begin
        m_last_patrol = f.now_ms;
        m_yaw += m_toward_neg ? -int'(m_step) : int'(m_step);
        if (m_yaw >= int'(m_yaw_lim)) begin
          m_yaw = m_yaw_lim;
          m_toward_neg = 1'b1;
        end else if (m_yaw <= -int'(m_yaw_lim)) begin
          m_yaw = -int'(m_yaw_lim);
          m_toward_neg = 1'b0;
        end
        m_pitch = 0;
      end
    end else if (m_yaw != 0 || m_pitch != 0) begin
      if (!m_returning) begin
        m_returning = 1'b1;
        m_ret_start = f.now_ms;
        m_org_yaw = m_yaw;
        m_org_pitch = m_pitch;
      end
      el = f.now_ms - m_ret_start;
      if (el >= m_return_ms) begin
        m_yaw = 0;
        m_pitch = 0;
        m_returning = 1'b0;
      end else begin
        m_yaw = ease_pos(m_org_yaw, el);
        m_pitch = ease_pos(m_org_pitch, el);
      end
    end else if (f.now_ms - m_last_motion >= m_idle_to) begin
      m_patrolling = 1'b1;
      m_last_patrol = f.now_ms;
      m_toward_neg = 1'b0;
    end
    g.redraw = 1'b0;
    if (m_yaw != m_shown_yaw || m_pitch != m_shown_pitch) begin
      m_shown_yaw = m_yaw;
      m_shown_pitch = m_pitch;
      g.redraw = 1'b1;
    end
    g.yaw_pos = m_yaw[6:0];
    g.pitch_pos = m_pitch[6:0];
    return g;
  endfunction

  // Driver: frames from the pending queue, random gaps
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_gaze.push_back(next_gaze(pending_frames.pop_front()));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_frames.size() > 0) begin
          // the head stays queued until it is accepted
          automatic frame_t f = pending_frames[0];
          in_ch.valid <= 1'b1;
          in_ch.sensor_reset <= f.sensor_reset;
          in_ch.has_sample <= f.has_sample;
          in_ch.yaw_angle <= f.yaw_angle;
          in_ch.pitch_angle <= f.pitch_angle;
          in_ch.now_ms <= f.now_ms;
          if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 11);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stalls, compare against oldest expectation
  int out_stall = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_gaze.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result yaw=%0d pitch=%0d",
                                         out_ch.yaw_pos, out_ch.pitch_pos);
        end else begin
          automatic gaze_t e = expected_gaze.pop_front();
          if (out_ch.yaw_pos !== e.yaw_pos || out_ch.pitch_pos !== e.pitch_pos ||
              out_ch.redraw !== e.redraw) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected yaw=%0d pitch=%0d redraw=%0b, got %0d %0d %0b",
                       e.yaw_pos, e.pitch_pos, e.redraw,
                       out_ch.yaw_pos, out_ch.pitch_pos, out_ch.redraw);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_stall <= $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus generation state
  logic [31:0] gen_now = '0;
  int gen_yaw = 0, gen_pitch = 0;

  function automatic int near_angle(int base);
    int d;
    case ($urandom_range(0, 4))
      0: d = $urandom_range(0, 2 * m_deadzone + 2) - int'(m_deadzone) - 1;
      1: d = m_deadzone + 1;
      2: d = -int'(m_deadzone) - 1;
      3: d = $urandom_range(0, 4000) - 2000;
      default: d = 0;
    endcase
    base = wrap_turn(base + d);
    return clamp_to(base, 23040);
  endfunction

  task automatic add_frame(bit sr, bit hs, int ya, int pa, logic [31:0] t);
    frame_t f;
    f.sensor_reset = sr;
    f.has_sample = hs;
    f.yaw_angle = 16'(ya);
    f.pitch_angle = 16'(pa);
    f.now_ms = t;
    pending_frames.push_back(f);
  endtask

  task automatic add_random_frame();
    int ya, pa;
    case ($urandom_range(0, 9))
      0: gen_now += $urandom();
      1, 2: gen_now += $urandom_range(0, 5);
      default: gen_now += $urandom_range(0, 300);
    endcase
    if ($urandom_range(0, 19) == 0) begin
      // noise: any 16-bit angles
      ya = $signed(16'($urandom()));
      pa = $signed(16'($urandom()));
    end else begin
      ya = near_angle(gen_yaw);
      pa = near_angle(gen_pitch);
      gen_yaw = ya;
      gen_pitch = pa;
    end
    add_frame($urandom_range(0, 24) == 0, $urandom_range(0, 3) != 0, ya, pa, gen_now);
  endtask

  task automatic drain();
    while (pending_frames.size() != 0 || in_ch.valid || expected_gaze.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(gdc_pkg::cfg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      gdc_pkg::CFG_DEADZONE:        m_deadzone = v[14:0];
      gdc_pkg::CFG_STEP_SIZE:       m_step = v[4:0];
      gdc_pkg::CFG_YAW_LIMIT:       m_yaw_lim = v[5:0];
      gdc_pkg::CFG_PITCH_LIMIT:     m_pitch_lim = v[5:0];
      gdc_pkg::CFG_RETURN_MS:       m_return_ms = v[15:0];
      gdc_pkg::CFG_IDLE_TIMEOUT:    m_idle_to = v;
      gdc_pkg::CFG_PATROL_INTERVAL: m_patrol_iv = v[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(int dz, int st, int yl, int pl, int rm, logic [31:0] it, int pi);
    write_reg(gdc_pkg::CFG_DEADZONE, dz);
    write_reg(gdc_pkg::CFG_STEP_SIZE, st);
    write_reg(gdc_pkg::CFG_YAW_LIMIT, yl);
    write_reg(gdc_pkg::CFG_PITCH_LIMIT, pl);
    write_reg(gdc_pkg::CFG_RETURN_MS, rm);
    write_reg(gdc_pkg::CFG_IDLE_TIMEOUT, it);
    write_reg(gdc_pkg::CFG_PATROL_INTERVAL, pi);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sensor_reset = 1'b0;
    in_ch.has_sample = 1'b0;
    in_ch.yaw_angle = '0;
    in_ch.pitch_angle = '0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    m_deadzone = 128; m_step = 4; m_yaw_lim = 20; m_pitch_lim = 10;
    m_return_ms = 500; m_idle_to = 120000; m_patrol_iv = 500;
    m_yaw = 0; m_pitch = 0; m_shown_yaw = 0; m_shown_pitch = 0;
    m_prev_yaw = 0; m_prev_pitch = 0;
    m_prev_ok = 0; m_returning = 0; m_patrolling = 0; m_toward_neg = 0;
    m_ret_start = 0; m_last_motion = 0; m_last_patrol = 0;
    m_org_yaw = 0; m_org_pitch = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames under reset defaults
    add_frame(0, 0, 0, 0, 0);
    add_frame(0, 1, 23040, -23040, 10);
    add_frame(0, 1, -23040, 23040, 20);          // exactly half turn each way
    add_frame(0, 1, -23040 + 129, 23040 - 129, 30); // just past deadzone
    add_frame(0, 1, -23040 + 257, 23040 - 257, 40); // exactly deadzone
    add_frame(0, 1, 22000, -22000, 50);          // wrap across 180
    add_frame(0, 1, 32767, -32768, 60);          // out-of-range angles
    add_frame(0, 1, -32768, 32767, 70);          // wide delta wrapped by one turn
    add_frame(1, 1, 0, 0, 80);                   // sensor reset forgets history
    add_frame(1, 0, 500, 500, 90);
    add_frame(0, 1, 1000, -1000, 100);
    add_frame(0, 0, 0, 0, 150);
    add_frame(0, 0, 0, 0, 400);
    add_frame(0, 0, 0, 0, 700);
    add_frame(0, 1, 5000, -5000, 32'hFFFF_FFF0);
    add_frame(0, 0, 0, 0, 32'hFFFF_FFFF);
    add_frame(0, 0, 0, 0, 32'd100);              // time wrap
    add_frame(0, 0, 0, 0, 32'd130000);
    add_frame(0, 0, 0, 0, 32'd131000);
    add_frame(0, 1, 5000, -5000, 32'd131500);
    gen_now = 131500;
    gen_yaw = 5000;
    gen_pitch = -5000;
    repeat (160) add_random_frame();
    drain();

    // Fast patrol, zero deadzone, limits of 60 and a step of 16
    set_all(0, 16, 60, 60, 1, 0, 0);
    repeat (160) add_random_frame();
    drain();

    // Long return, tiny step and limits, patrol soon
    set_all(1, 1, 1, 1, 65535, 600, 100);
    repeat (160) add_random_frame();
    drain();

    // Half-turn deadzone: no wrapped delta exceeds it, so no motion; longest idle timeout
    set_all(23040, 7, 33, 17, 2000, 32'hFFFF_FFFF, 65535);
    repeat (150) add_random_frame();
    drain();

    // Mixed midrange setting with quick patrol
    set_all(64, 3, 13, 9, 300, 1000, 200);
    repeat (150) add_random_frame();
    drain();

    // Final stretch without idling
    set_all(32, 5, 25, 12, 800, 1500, 300);
    quiet = 1'b1;
    repeat (150) add_random_frame();
    drain();

    if (mismatches == 0 && expected_gaze.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end
endmodule

[files.f]
rtl/gdc_pkg.sv
rtl/gdc_in_if.sv
rtl/gdc_out_if.sv
rtl/gdc_front.sv
rtl/gdc_cmd_fifo.sv
rtl/gdc_ease.sv
rtl/gdc_back.sv
rtl/gaze_direction_controller.sv
rtl/gdc_checker.sv
tb/tb_top.sv
